/* design/caf_pkg.sv */
// caf_pkg: shared types, status codes and constants of the chunk walker
// no dependencies; compile first
`default_nettype none

package caf_pkg;

  localparam int unsigned SIZE_BITS_DEF = 48;
  localparam int unsigned CFG_W         = 48;
  localparam int unsigned FSZ_W         = 48;
  localparam int unsigned SHIFT_W       = 64;

  localparam logic [CFG_W-1:0] MAX_FILE_SIZE_RST = 48'd2199023255551;

  localparam int unsigned SIG_LEN          = 12;
  localparam int unsigned HDR_LEN          = 12;
  localparam int unsigned FIRST_HDR_OFFSET = 8;
  localparam int unsigned FIRST_SIZE_END   = 19;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CHECK  = 3'd1,
    ST_WALK   = 3'd2,
    ST_END    = 3'd3,
    ST_REJECT = 3'd4,
    ST_ABORT  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [FSZ_W-1:0] walk_size;
  } out_beat_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } in_stage_t;

  // signature: "caff" 00 01 00 00 "desc"
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h63;
      4'd1:    b = 8'h61;
      4'd2:    b = 8'h66;
      4'd3:    b = 8'h66;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = 8'h00;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h64;
      4'd9:    b = 8'h65;
      4'd10:   b = 8'h73;
      4'd11:   b = 8'h63;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* design/caf_stream_if.sv */
// caf_stream_if: valid/ready channel carrying one payload beat
// payload type is set by the instantiating module
`default_nettype none

interface caf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/caf_in_reg.sv */
// caf_in_reg: input register stage of the chunk walker
// depends on caf_pkg and caf_stream_if
`default_nettype none

module caf_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  caf_stream_if.sink          in_i,
  input  wire logic           advance_i,
  output caf_pkg::in_stage_t  stage_o
);
  import caf_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      beat_q <= in_i.payload;
    end
  end

  assign stage_o = {valid_q, beat_q};

endmodule

`default_nettype wire

/* design/caf_walk_core.sv */
// caf_walk_core: walker state, per-byte update and result register
// depends on caf_pkg and caf_stream_if
`default_nettype none

module caf_walk_core #(
  parameter int unsigned SIZE_BITS = caf_pkg::SIZE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [caf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire caf_pkg::in_stage_t        stage_i,
  output logic                           advance_o,
  caf_stream_if.source                   out_o
);
  import caf_pkg::*;

  localparam int unsigned SUM_W = SHIFT_W + 2;
  localparam logic [SIZE_BITS-1:0] SIZE_MASK = '1;

  logic [CFG_W-1:0]     max_q;
  status_e              phase_q, phase_d;
  logic [SIZE_BITS-1:0] bp_q, bp_d;
  logic [SIZE_BITS-1:0] nho_q, nho_d;
  logic [SHIFT_W-1:0]   ss_q, ss_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  status_e              phase_c;
  logic [SIZE_BITS-1:0] bp_c, nho_c;
  logic [SHIFT_W-1:0]   ss_c;
  logic [7:0]           b;
  logic                 active;
  logic [SUM_W-1:0]     sum;
  logic [SIZE_BITS-1:0] sum_sat;
  logic [SIZE_BITS:0]   hdr_last;
  logic [SHIFT_W-1:0]   max_ext;
  logic [SIZE_BITS-1:0] fsz;

  assign advance_o = stage_i.valid && (!out_valid_q || out_o.ready);
  assign b         = stage_i.beat.data_byte;

  // restart on start flag
  always_comb begin
    phase_c = phase_q;
    bp_c    = bp_q;
    nho_c   = nho_q;
    ss_c    = ss_q;
    if (stage_i.beat.start_of_file) begin
      phase_c = ST_CHECK;
      bp_c    = '0;
      nho_c   = SIZE_BITS'(FIRST_HDR_OFFSET);
      ss_c    = '0;
    end
  end

  assign active   = (phase_c == ST_CHECK) || (phase_c == ST_WALK);
  assign ss_d     = active ? {ss_c[SHIFT_W-9:0], b} : ss_c;
  assign max_ext  = SHIFT_W'(max_q);
  assign sum      = SUM_W'(nho_c) + SUM_W'(ss_d) + SUM_W'(HDR_LEN);
  assign sum_sat  = (sum[SUM_W-1:SIZE_BITS] != '0) ? SIZE_MASK : sum[SIZE_BITS-1:0];
  assign hdr_last = {1'b0, nho_c} + (SIZE_BITS+1)'(HDR_LEN - 1);

  always_comb begin
    phase_d = phase_c;
    nho_d   = nho_c;
    bp_d    = bp_c;
    if (phase_c == ST_CHECK) begin
      if (bp_c < SIZE_BITS'(SIG_LEN)) begin
        if (b != sig_byte(bp_c[3:0])) begin
          phase_d = ST_REJECT;
        end
      end else if (bp_c == SIZE_BITS'(FIRST_SIZE_END)) begin
        if (ss_d >= max_ext) begin
          phase_d = ST_REJECT;
        end else begin
          nho_d   = sum_sat;
          phase_d = ST_WALK;
        end
      end
    end else if (phase_c == ST_WALK && nho_c != SIZE_MASK) begin
      if (bp_c == nho_c && b == 8'h00) begin
        nho_d   = (bp_c != '0) ? bp_c - SIZE_BITS'(1) : '0;
        phase_d = ST_END;
      end else if ({1'b0, bp_c} == hdr_last) begin
        if (ss_d > max_ext) begin
          phase_d = ST_ABORT;
        end else begin
          nho_d = sum_sat;
        end
      end
    end
    if (active && bp_c != SIZE_MASK) begin
      bp_d = bp_c + SIZE_BITS'(1);
    end
  end

  assign fsz = (phase_d == ST_IDLE || phase_d == ST_REJECT) ? '0 : nho_d;

  always_comb begin
    out_d.status    = phase_d;
    out_d.walk_size = FSZ_W'(fsz);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_FILE_SIZE_RST;
      phase_q     <= ST_IDLE;
      bp_q        <= '0;
      nho_q       <= SIZE_BITS'(FIRST_HDR_OFFSET);
      ss_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (advance_o) begin
        phase_q <= phase_d;
        bp_q    <= bp_d;
        nho_q   <= nho_d;
        ss_q    <= ss_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

/* design/caf_chunk_walk_size_finder.sv */
// caf_chunk_walk_size_finder: top level of the chunk walker
// depends on caf_pkg, caf_stream_if, caf_in_reg and caf_walk_core
//
// Takes one file byte per beat and returns one result beat per byte: the walk
// status and the offset of the next chunk header (final size once the end is
// found). Throughput is one byte per clock while the result side is not stalled;
// each byte passes the input register and the result register, and the whole
// per-byte update (signature compare, 64-bit size shift, one saturating add and
// the header compares) sits between them. The user must write the size limit
// register via cfg_we_i while no byte is in flight; the block does not check.
`default_nettype none

module caf_chunk_walk_size_finder #(
  parameter int unsigned SIZE_BITS = caf_pkg::SIZE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [caf_pkg::CFG_W-1:0] cfg_wdata_i,
  caf_stream_if.sink                     in_i,
  caf_stream_if.source                   out_o
);
  import caf_pkg::*;

  in_stage_t stage;
  logic      advance;

  caf_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  caf_walk_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* design/caf_walk_checker.sv */
// caf_walk_checker: port-level assertions for the chunk walker
// depends on caf_pkg; bound to caf_chunk_walk_size_finder
`default_nettype none

module caf_walk_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire caf_pkg::out_beat_t out_beat_i
);
  import caf_pkg::*;

  logic [1:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      inflight_d = inflight_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // at most the input and result registers hold beats
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 2'd2)
    else $error("more beats in flight than pipeline registers");

  // no result without a byte behind it
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 2'd0 |-> !out_valid_i)
    else $error("result beat with no byte in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("stalled result changed");

  // idle and rejected report no size
  a_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_beat_i.status == ST_IDLE || out_beat_i.status == ST_REJECT)
      |-> out_beat_i.walk_size == '0)
    else $error("nonzero size with idle or rejected status");

endmodule

bind caf_chunk_walk_size_finder caf_walk_checker u_walk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.payload)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: testbench of caf_chunk_walk_size_finder, one file byte in and one status beat out
// depends on caf_pkg, caf_stream_if and the design; a scoreboard class predicts every result

module tb_top;
  import caf_pkg::*;

  localparam logic [FSZ_W-1:0] SIZE_SAT       = '1;
  localparam int unsigned      WATCHDOG_LIMIT = 5000;
  localparam int unsigned      SEG_BEATS      = 325;

  typedef enum int {
    FILE_END,
    FILE_ABORT,
    FILE_BIG_FIRST,
    FILE_BAD_SIG,
    FILE_SAT,
    FILE_CUT
  } file_kind_e;

  class chunk_walk_scoreboard;
    localparam logic [FSZ_W-1:0] OFFSET_SAT = '1;
    logic [7:0]         magic [SIG_LEN];
    logic [CFG_W-1:0]   size_limit;
    logic [FSZ_W-1:0]   byte_pos;
    logic [FSZ_W-1:0]   next_hdr;
    logic [SHIFT_W-1:0] size_sr;
    status_e            phase;
    out_beat_t          result_q [$];
    int                 errors;

    function new();
      magic      = '{8'h63, 8'h61, 8'h66, 8'h66, 8'h00, 8'h01,
                     8'h00, 8'h00, 8'h64, 8'h65, 8'h73, 8'h63};
      size_limit = MAX_FILE_SIZE_RST;
      byte_pos   = '0;
      next_hdr   = FSZ_W'(FIRST_HDR_OFFSET);
      size_sr    = '0;
      phase      = ST_IDLE;
      errors     = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      size_limit = v;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function logic [FSZ_W-1:0] sat_sum(logic [FSZ_W-1:0] a, logic [SHIFT_W-1:0] b);
      logic [SHIFT_W+1:0] s;
      s = {{(SHIFT_W+2-FSZ_W){1'b0}}, a} + {2'b00, b};
      if (s > {{(SHIFT_W+2-FSZ_W){1'b0}}, OFFSET_SAT}) return OFFSET_SAT;
      return s[FSZ_W-1:0];
    endfunction

    function void note_input(in_beat_t beat);
      status_e          entry;
      logic [FSZ_W-1:0] rel;
      out_beat_t        res;
      if (beat.start_of_file) begin
        phase    = ST_CHECK;
        byte_pos = '0;
        next_hdr = FSZ_W'(FIRST_HDR_OFFSET);
        size_sr  = '0;
      end
      entry = phase;
      if (entry == ST_CHECK || entry == ST_WALK) begin
        size_sr = {size_sr[SHIFT_W-9:0], beat.data_byte};
        if (entry == ST_CHECK) begin
          if (byte_pos < SIG_LEN) begin
            if (beat.data_byte != magic[byte_pos[3:0]]) phase = ST_REJECT;
          end else if (byte_pos == FIRST_SIZE_END) begin
            if (size_sr >= {{(SHIFT_W-CFG_W){1'b0}}, size_limit}) begin
              phase = ST_REJECT;
            end else begin
              next_hdr = sat_sum(sat_sum(next_hdr, HDR_LEN), size_sr);
              phase    = ST_WALK;
            end
          end
        end else if (next_hdr != OFFSET_SAT && byte_pos >= next_hdr) begin
          rel = byte_pos - next_hdr;
          if (rel == 0 && beat.data_byte == 8'h00) begin
            next_hdr = (byte_pos > 0) ? byte_pos - 1 : '0;
            phase    = ST_END;
          end else if (rel == HDR_LEN - 1) begin
            if (size_sr > {{(SHIFT_W-CFG_W){1'b0}}, size_limit}) phase = ST_ABORT;
            else next_hdr = sat_sum(sat_sum(next_hdr, HDR_LEN), size_sr);
          end
        end
        if (byte_pos < OFFSET_SAT) byte_pos++;
      end
      res.status    = phase;
      res.walk_size = (phase == ST_IDLE || phase == ST_REJECT) ? '0 : next_hdr;
      result_q.push_back(res);
    endfunction

    function void check(out_beat_t got);
      out_beat_t want;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: status %0d walk_size %0d",
                 $time, got.status, got.walk_size);
        return;
      end
      want = result_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
      end
      if (got.walk_size !== want.walk_size) begin
        errors++;
        $display("%0t: walk_size mismatch: expected %0d actual %0d",
                 $time, want.walk_size, got.walk_size);
      end
    endfunction
  endclass

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int unsigned      send_idle = 28;
  int unsigned      recv_idle = 51;
  int unsigned      quiet_cycles = 0;
  int unsigned      beats_sent = 0;
  in_beat_t         file_q [$];

  chunk_walk_scoreboard sb = new();

  caf_stream_if #(.payload_t(in_beat_t))  in_if ();
  caf_stream_if #(.payload_t(out_beat_t)) out_if ();

  caf_chunk_walk_size_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check(out_if.payload);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("caf_chunk_walk_size_finder test failed");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b, logic sof);
    in_beat_t t;
    t.data_byte     = b;
    t.start_of_file = sof;
    file_q.push_back(t);
  endfunction

  function automatic void add_random(int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom), 1'b0);
  endfunction

  function automatic void add_size(logic [SHIFT_W-1:0] s);
    for (int i = 7; i >= 0; i--) add_byte(s[i*8 +: 8], 1'b0);
  endfunction

  function automatic void add_noise(int n);
    logic [7:0] b;
    logic       sof;
    for (int i = 0; i < n; i++) begin
      b   = 8'($urandom);
      sof = ($urandom_range(15) == 0);
      if (sof && $urandom_range(1) == 0) b = sb.magic[0];
      add_byte(b, sof);
    end
  endfunction

  function automatic logic [SHIFT_W-1:0] first_size();
    int unsigned hi;
    if (sb.size_limit <= 40 && $urandom_range(3) == 0) return SHIFT_W'(sb.size_limit - 1);
    hi = (sb.size_limit < 25) ? int'(sb.size_limit) - 1 : 24;
    return SHIFT_W'($urandom_range(hi, 0));
  endfunction

  function automatic logic [SHIFT_W-1:0] next_chunk_len();
    int unsigned hi;
    if (sb.size_limit <= 40 && $urandom_range(3) == 0) return SHIFT_W'(sb.size_limit);
    hi = (sb.size_limit < 24) ? int'(sb.size_limit) : 24;
    if ($urandom_range(19) == 0) hi = 60;
    if (hi > sb.size_limit) hi = int'(sb.size_limit);
    return SHIFT_W'($urandom_range(hi, 0));
  endfunction

  function automatic logic [SHIFT_W-1:0] oversize();
    logic [SHIFT_W-1:0] s;
    case ($urandom_range(2))
      0: s = sb.size_limit + 1;
      1: s = sb.size_limit + $urandom_range(1000, 1);
      default: begin
        s = {$urandom, $urandom};
        s[CFG_W + $urandom_range(SHIFT_W-CFG_W-1)] = 1'b1;
      end
    endcase
    return s;
  endfunction

  function automatic void add_header(logic [SHIFT_W-1:0] s);
    add_byte(8'($urandom_range(255, 1)), 1'b0);
    add_random(3);
    add_size(s);
  endfunction

  function automatic void build_file(file_kind_e kind, int n_chunks);
    int                 base;
    int                 k;
    in_beat_t           t;
    logic [SHIFT_W-1:0] s;
    base = file_q.size();
    for (int i = 0; i < SIG_LEN; i++) add_byte(sb.magic[i], i == 0);
    if (kind == FILE_BAD_SIG) begin
      k = $urandom_range(SIG_LEN-1);
      t = file_q[base+k];
      t.data_byte ^= 8'($urandom_range(255, 1));
      file_q[base+k] = t;
      add_random($urandom_range(8));
      return;
    end
    if (kind == FILE_BIG_FIRST) begin
      s = ($urandom_range(2) == 0) ? {{(SHIFT_W-CFG_W){1'b0}}, sb.size_limit} : oversize();
      add_size(s);
      add_random($urandom_range(6));
      return;
    end
    s = first_size();
    add_size(s);
    add_random(int'(s));
    for (int c = 0; c < n_chunks; c++) begin
      s = next_chunk_len();
      add_header(s);
      add_random(int'(s));
    end
    case (kind)
      FILE_END: begin
        add_byte(8'h00, 1'b0);
        add_random($urandom_range(14));
      end
      FILE_ABORT: begin
        add_header(oversize());
        add_random($urandom_range(5));
      end
      FILE_SAT: begin
        add_header({{(SHIFT_W-FSZ_W){1'b0}}, SIZE_SAT - $urandom_range(40)});
        add_random($urandom_range(30, 4));
      end
      default: begin
        // truncate anywhere so the next start lands mid-file
        add_byte(8'h00, 1'b0);
        add_random(11);
        k = $urandom_range(file_q.size() - base, 1);
        while (file_q.size() > base + k) void'(file_q.pop_back());
      end
    endcase
  endfunction

  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_stream();
    while (file_q.size() > 0) begin
      send_beat(file_q.pop_front());
      beats_sent++;
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic random_case();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) build_file(FILE_END, $urandom_range(4));
    else if (r < 70) build_file(FILE_ABORT, $urandom_range(3));
    else if (r < 76) build_file(FILE_BAD_SIG, 0);
    else if (r < 82) build_file(FILE_BIG_FIRST, 0);
    else if (r < 88) build_file(FILE_CUT, $urandom_range(3));
    else if (r < 92) build_file(FILE_SAT, $urandom_range(2));
    else add_noise($urandom_range(12, 1));
    send_stream();
  endtask

  task automatic run_random(int unsigned n, bit with_pause);
    int unsigned target;
    target = beats_sent + n;
    while (beats_sent < target) begin
      random_case();
      if (with_pause && beats_sent > target - n / 2) begin
        drain();
        with_pause = 0;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] lim;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset limit
    build_file(FILE_END, 0);
    build_file(FILE_END, 2);
    build_file(FILE_BAD_SIG, 0);
    build_file(FILE_BIG_FIRST, 0);
    build_file(FILE_ABORT, 1);
    build_file(FILE_CUT, 1);
    add_byte(8'hff, 1'b1);
    add_byte(8'h00, 1'b1);
    add_noise(4);
    send_stream();

    // smallest limit: sizes at and just past the limit
    write_limit(CFG_W'(20));
    build_file(FILE_END, 3);
    build_file(FILE_ABORT, 0);
    build_file(FILE_BIG_FIRST, 0);
    build_file(FILE_END, 1);
    send_stream();

    // largest limit: a file whose offset saturates so no later header is found, then a normal file
    write_limit(SIZE_SAT);
    build_file(FILE_SAT, 1);
    build_file(FILE_END, 1);
    send_stream();

    write_limit(MAX_FILE_SIZE_RST);
    run_random(SEG_BEATS, 1'b1);
    write_limit(CFG_W'(20));
    run_random(SEG_BEATS, 1'b0);

    send_idle = 51;
    recv_idle = 28;
    write_limit(SIZE_SAT);
    run_random(SEG_BEATS, 1'b0);
    write_limit(CFG_W'($urandom_range(1000, 20)));
    run_random(SEG_BEATS, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    lim = {16'($urandom), $urandom};
    if (lim < 20) lim = CFG_W'(20);
    write_limit(lim);
    run_random(SEG_BEATS, 1'b0);
    write_limit(CFG_W'(21));
    run_random(SEG_BEATS, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("caf_chunk_walk_size_finder test passed");
    end else begin
      $display("caf_chunk_walk_size_finder test failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/caf_pkg.sv
design/caf_stream_if.sv
design/caf_in_reg.sv
design/caf_walk_core.sv
design/caf_chunk_walk_size_finder.sv
design/caf_walk_checker.sv
tb/tb_top.sv
